// ----- design/gppds_pkg.sv -----
// Shared types and constants for the greedy peak picker with disc suppression.
`default_nettype none

package gppds_pkg;

  localparam int COLS_W   = 10;
  localparam int ROWS_W   = 10;
  localparam int PICKS_W  = 7;
  localparam int RAD_W    = 9;
  localparam int CFG_W    = 10;
  localparam int CFG_IDXW = 2;
  localparam int PIX_W    = 8;
  localparam int COORD_W  = 9;
  localparam int RSQ_W    = 2 * RAD_W;
  localparam int SUM_W    = RSQ_W + 1;

  localparam logic [CFG_IDXW-1:0] REG_COLS   = 2'd0;
  localparam logic [CFG_IDXW-1:0] REG_ROWS   = 2'd1;
  localparam logic [CFG_IDXW-1:0] REG_PICKS  = 2'd2;
  localparam logic [CFG_IDXW-1:0] REG_RADIUS = 2'd3;

  localparam logic [COLS_W-1:0]  COLS_RST   = 10'd512;
  localparam logic [ROWS_W-1:0]  ROWS_RST   = 10'd512;
  localparam logic [PICKS_W-1:0] PICKS_RST  = 7'd1;
  localparam logic [RAD_W-1:0]   RADIUS_RST = 9'd20;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_START = 1'b1;

  typedef struct packed {
    logic             cmd;
    logic [PIX_W-1:0] pixel_value;
  } in_t;

  typedef struct packed {
    logic [COORD_W-1:0] peak_x;
    logic [COORD_W-1:0] peak_y;
    logic               found;
    logic               last;
  } out_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic start_run;
    logic scan_step;
    logic emit;
    logic next_pick;
    logic disc_set0;
    logic disc_set1;
    logic disc_row;
    logic disc_step;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic total_ok;
    logic scan_end;
    logic found;
    logic last_pick;
    logic out_free;
    logic row_end;
    logic disc_end;
  } stat_t;

endpackage

`default_nettype wire

// ----- design/greedy_peak_pick_disc_suppress_top.sv -----
// Top level of the greedy peak picker with disc suppression.
//
//  channel | signals                                  | direction | moves
//  --------+------------------------------------------+-----------+-------------------------
//  in      | in_valid, in_stall, in_data              | in        | load pixel or start
//  out     | out_valid, out_stall, out_data           | out       | one pick per transaction
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data| in        | register write
//
// Loads can stream at one per cycle while in_stall is low.
// A start runs cfg_picks picks (clamped to 1..MAX_PICKS); each pick scans the whole image
// once through the single read port of the pixel memory and hands off the result, then, if
// a peak was found and more picks remain, sweeps the disc bounding box one pixel a cycle per row.
// in_stall is high for the whole run, and after reset and every cfg write until settled is set.
// Reset is synchronous; the pixel memory is not cleared. A stalled result blocks the next pick.
`default_nettype none

module greedy_peak_pick_disc_suppress_top #(
  parameter int MAX_COLS  = 512,
  parameter int MAX_ROWS  = 512,
  parameter int MAX_PICKS = 64
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire gppds_pkg::in_t                  in_data,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output gppds_pkg::out_t                      out_data,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [gppds_pkg::CFG_IDXW-1:0]  cfg_index,
  input  wire logic [gppds_pkg::CFG_W-1:0]     cfg_data
);

  gppds_pkg::cmd_t  cmd;
  gppds_pkg::stat_t stat;

  assign cfg_ready = 1'b1;

  gppds_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_cmd   (in_data.cmd),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  gppds_dp #(
    .MAX_COLS  (MAX_COLS),
    .MAX_ROWS  (MAX_ROWS),
    .MAX_PICKS (MAX_PICKS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

`ifndef SYNTH
  // an empty pick carries zero coordinates
  a_empty_pick_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.found |-> out_data.peak_x == '0 && out_data.peak_y == '0)
    else $error("empty pick with nonzero coordinates");

  // a run is still going while any pick but its last is held
  a_run_continues: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.last |-> in_stall)
    else $error("input taken in the middle of a run");

  // image size is recomputed after a register write before any input is taken
  a_cfg_settle: assert property (@(posedge clk) disable iff (rst)
    cfg_valid && cfg_ready |=> in_stall)
    else $error("input taken before config settled");
`endif

endmodule

`default_nettype wire

// ----- design/gppds_dp.sv -----
// Datapath: config registers, pixel and mask memories, scan compare, disc sweep, output register.
`default_nettype none

module gppds_dp #(
  parameter int MAX_COLS  = 512,
  parameter int MAX_ROWS  = 512,
  parameter int MAX_PICKS = 64
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_valid,
  input  wire logic [gppds_pkg::CFG_IDXW-1:0]   cfg_index,
  input  wire logic [gppds_pkg::CFG_W-1:0]      cfg_data,
  input  wire gppds_pkg::in_t                   in_data,
  input  wire gppds_pkg::cmd_t                  cmd,
  output gppds_pkg::stat_t                      stat,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output gppds_pkg::out_t                       out_data
);

  localparam int DEPTH = MAX_COLS * MAX_ROWS;
  localparam int AW    = $clog2(DEPTH);
  localparam int TW    = $clog2(DEPTH + 1);
  localparam int XW    = $clog2(MAX_COLS);
  localparam int YW    = $clog2(MAX_ROWS);
  localparam int CCW   = $clog2(MAX_COLS + 1);
  localparam int RCW   = $clog2(MAX_ROWS + 1);
  localparam int PW    = $clog2(MAX_PICKS + 1);
  localparam int MW    = (XW > YW) ? XW : YW;
  localparam int SW    = ((MW > gppds_pkg::RAD_W) ? MW : gppds_pkg::RAD_W) + 2;

  // configuration
  logic [gppds_pkg::COLS_W-1:0]  cfg_cols;
  logic [gppds_pkg::ROWS_W-1:0]  cfg_rows;
  logic [gppds_pkg::PICKS_W-1:0] cfg_picks;
  logic [gppds_pkg::RAD_W-1:0]   cfg_radius;
  logic                          settled;

  logic [CCW-1:0] cols_cl;
  logic [RCW-1:0] rows_cl;
  logic [PW-1:0]  picks_cl;

  logic [CCW-1:0] cols_c;
  logic [XW-1:0]  cols_m1;
  logic [YW-1:0]  rows_m1;
  logic [TW-1:0]  total;
  logic [PW-1:0]  picks_m1;

  // load side
  logic [TW-1:0]  ptr;
  logic [TW-1:0]  ptr_eff;

  // memories
  logic [gppds_pkg::PIX_W-1:0] sal_mem [DEPTH];
  logic                        open_mem [DEPTH];
  logic [gppds_pkg::PIX_W-1:0] sal_q;
  logic                        open_q;

  // scan
  logic [AW-1:0]               scan_addr;
  logic [XW-1:0]               sx;
  logic [YW-1:0]               sy;
  logic                        s1_valid;
  logic [XW-1:0]               s1_x;
  logic [YW-1:0]               s1_y;
  logic                        first;
  logic [PW-1:0]               k;
  logic                        have;
  logic [gppds_pkg::PIX_W-1:0] best_val;
  logic [XW-1:0]               best_x;
  logic [YW-1:0]               best_y;

  // disc sweep
  logic [XW-1:0]                dx0;
  logic [XW-1:0]                dx1;
  logic [YW-1:0]                dy1;
  logic [XW-1:0]                dxc;
  logic [YW-1:0]                dyc;
  logic [AW-1:0]                base;
  logic [gppds_pkg::RSQ_W-1:0]  r2;
  logic [gppds_pkg::RSQ_W-1:0]  dy2;
  logic                         d1_valid;
  logic [AW-1:0]                d1_addr;
  logic [gppds_pkg::RSQ_W-1:0]  d1_dx2;

  logic signed [SW-1:0] cx_s;
  logic signed [SW-1:0] cy_s;
  logic signed [SW-1:0] r_s;
  logic signed [SW-1:0] xlo;
  logic signed [SW-1:0] xhi;
  logic signed [SW-1:0] ylo;
  logic signed [SW-1:0] yhi;
  logic signed [SW-1:0] dx_s;
  logic signed [SW-1:0] dy_s;
  logic [XW-1:0]        x0_c;
  logic [XW-1:0]        x1_c;
  logic [YW-1:0]        y0_c;
  logic [YW-1:0]        y1_c;
  logic [gppds_pkg::RAD_W-1:0] dxabs;
  logic [gppds_pkg::RAD_W-1:0] dyabs;
  logic                 in_disc;

  // ---------------- configuration ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_cols   <= gppds_pkg::COLS_RST;
      cfg_rows   <= gppds_pkg::ROWS_RST;
      cfg_picks  <= gppds_pkg::PICKS_RST;
      cfg_radius <= gppds_pkg::RADIUS_RST;
      settled    <= 1'b0;
    end else begin
      settled <= !cfg_valid;
      if (cfg_valid) begin
        unique case (cfg_index)
          gppds_pkg::REG_COLS:   cfg_cols   <= cfg_data[gppds_pkg::COLS_W-1:0];
          gppds_pkg::REG_ROWS:   cfg_rows   <= cfg_data[gppds_pkg::ROWS_W-1:0];
          gppds_pkg::REG_PICKS:  cfg_picks  <= cfg_data[gppds_pkg::PICKS_W-1:0];
          gppds_pkg::REG_RADIUS: cfg_radius <= cfg_data[gppds_pkg::RAD_W-1:0];
        endcase
      end
    end
  end

  always_comb begin
    if (cfg_cols == '0) begin
      cols_cl = CCW'(1);
    end else if (32'(cfg_cols) > 32'(MAX_COLS)) begin
      cols_cl = CCW'(MAX_COLS);
    end else begin
      cols_cl = CCW'(cfg_cols);
    end
    if (cfg_rows == '0) begin
      rows_cl = RCW'(1);
    end else if (32'(cfg_rows) > 32'(MAX_ROWS)) begin
      rows_cl = RCW'(MAX_ROWS);
    end else begin
      rows_cl = RCW'(cfg_rows);
    end
    if (cfg_picks == '0) begin
      picks_cl = PW'(1);
    end else if (32'(cfg_picks) > 32'(MAX_PICKS)) begin
      picks_cl = PW'(MAX_PICKS);
    end else begin
      picks_cl = PW'(cfg_picks);
    end
  end

  // derived sizes, registered from the clamped config values
  always_ff @(posedge clk) begin
    cols_c   <= cols_cl;
    cols_m1  <= XW'(cols_cl - 1'b1);
    rows_m1  <= YW'(rows_cl - 1'b1);
    total    <= TW'(TW'(cols_cl) * TW'(rows_cl));
    picks_m1 <= PW'(picks_cl - 1'b1);
  end

  // ---------------- load pointer ----------------
  assign ptr_eff = (ptr >= total) ? '0 : ptr;

  always_ff @(posedge clk) begin
    if (rst) begin
      ptr <= '0;
    end else if (cmd.start_run) begin
      ptr <= '0;
    end else if (cmd.load) begin
      ptr <= ptr_eff + 1'b1;
    end
  end

  // ---------------- memories ----------------
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sal_mem[AW'(ptr_eff)] <= in_data.pixel_value;
    end
    sal_q <= sal_mem[scan_addr];
  end

  // first scan of a run reopens every pixel it visits
  always_ff @(posedge clk) begin
    if (cmd.scan_step && first) begin
      open_mem[scan_addr] <= 1'b1;
    end else if (d1_valid && in_disc) begin
      open_mem[d1_addr] <= 1'b0;
    end
    open_q <= open_mem[scan_addr];
  end

  // ---------------- scan ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      first    <= 1'b0;
      k        <= '0;
      have     <= 1'b0;
    end else begin
      s1_valid <= cmd.scan_step;
      if (cmd.start_run) begin
        first <= 1'b1;
        k     <= '0;
      end else if (cmd.next_pick) begin
        first <= 1'b0;
        k     <= k + 1'b1;
      end
      if (cmd.start_run || cmd.next_pick) begin
        have <= 1'b0;
      end else if (s1_valid && (first || open_q) && (!have || sal_q > best_val)) begin
        have <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start_run || cmd.next_pick) begin
      scan_addr <= '0;
      sx        <= '0;
      sy        <= '0;
      best_val  <= '0;
      best_x    <= '0;
      best_y    <= '0;
    end else begin
      if (cmd.scan_step) begin
        scan_addr <= scan_addr + 1'b1;
        s1_x      <= sx;
        s1_y      <= sy;
        if (sx == cols_m1) begin
          sx <= '0;
          sy <= sy + 1'b1;
        end else begin
          sx <= sx + 1'b1;
        end
      end
      if (s1_valid && (first || open_q) && (!have || sal_q > best_val)) begin
        best_val <= sal_q;
        best_x   <= s1_x;
        best_y   <= s1_y;
      end
    end
  end

  // ---------------- disc sweep ----------------
  always_comb begin
    cx_s = $signed(SW'(best_x));
    cy_s = $signed(SW'(best_y));
    r_s  = $signed(SW'(cfg_radius));
    xlo  = cx_s - r_s;
    xhi  = cx_s + r_s;
    ylo  = cy_s - r_s;
    yhi  = cy_s + r_s;
    x0_c = (xlo < 0) ? '0 : XW'(xlo);
    x1_c = (xhi > $signed(SW'(cols_m1))) ? cols_m1 : XW'(xhi);
    y0_c = (ylo < 0) ? '0 : YW'(ylo);
    y1_c = (yhi > $signed(SW'(rows_m1))) ? rows_m1 : YW'(yhi);
    dx_s = $signed(SW'(dxc)) - cx_s;
    dy_s = $signed(SW'(dyc)) - cy_s;
    // offsets stay within the radius, so nine bits hold the magnitude
    dxabs = gppds_pkg::RAD_W'((dx_s < 0) ? -dx_s : dx_s);
    dyabs = gppds_pkg::RAD_W'((dy_s < 0) ? -dy_s : dy_s);
    in_disc = (gppds_pkg::SUM_W'(d1_dx2) + gppds_pkg::SUM_W'(dy2))
              <= gppds_pkg::SUM_W'(r2);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      d1_valid <= 1'b0;
    end else begin
      d1_valid <= cmd.disc_step;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.disc_set0) begin
      dx0 <= x0_c;
      dx1 <= x1_c;
      dyc <= y0_c;
      dy1 <= y1_c;
      r2  <= gppds_pkg::RSQ_W'(cfg_radius) * gppds_pkg::RSQ_W'(cfg_radius);
    end
    if (cmd.disc_set1) begin
      base <= AW'(AW'(dyc) * AW'(cols_c));
    end
    if (cmd.disc_row) begin
      dy2 <= gppds_pkg::RSQ_W'(dyabs) * gppds_pkg::RSQ_W'(dyabs);
      dxc <= dx0;
    end
    if (cmd.disc_step) begin
      d1_addr <= base + AW'(dxc);
      d1_dx2  <= gppds_pkg::RSQ_W'(dxabs) * gppds_pkg::RSQ_W'(dxabs);
      if (dxc == dx1) begin
        if (dyc != dy1) begin
          dyc  <= dyc + 1'b1;
          base <= base + AW'(cols_c);
        end
      end else begin
        dxc <= dxc + 1'b1;
      end
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data.peak_x <= gppds_pkg::COORD_W'(best_x);
      out_data.peak_y <= gppds_pkg::COORD_W'(best_y);
      out_data.found  <= have;
      out_data.last   <= (k == picks_m1);
    end
  end

  // ---------------- status ----------------
  always_comb begin
    stat.total_ok  = settled;
    stat.scan_end  = (sx == cols_m1) && (sy == rows_m1);
    stat.found     = have;
    stat.last_pick = (k == picks_m1);
    stat.out_free  = !out_valid || !out_stall;
    stat.row_end   = (dxc == dx1);
    stat.disc_end  = (dyc == dy1);
  end

endmodule

`default_nettype wire

// ----- design/gppds_ctrl.sv -----
// Controller: sequences loads, pick scans, result hand-off and disc sweeps.
`default_nettype none

module gppds_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  input  wire logic              in_cmd,
  output logic                   in_stall,
  input  wire gppds_pkg::stat_t  stat,
  output gppds_pkg::cmd_t        cmd
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_SCAN   = 4'd1;
  localparam logic [3:0] S_SDRAIN = 4'd2;
  localparam logic [3:0] S_EMIT   = 4'd3;
  localparam logic [3:0] S_DSET0  = 4'd4;
  localparam logic [3:0] S_DSET1  = 4'd5;
  localparam logic [3:0] S_DROW   = 4'd6;
  localparam logic [3:0] S_DRUN   = 4'd7;
  localparam logic [3:0] S_DDRAIN = 4'd8;

  logic [3:0] state;
  logic [3:0] state_next;
  logic       take;

  assign in_stall = !((state == S_IDLE) && stat.total_ok);
  assign take     = in_valid && !in_stall;

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (take) begin
          if (in_cmd == gppds_pkg::CMD_START) begin
            cmd.start_run = 1'b1;
            state_next    = S_SCAN;
          end else begin
            cmd.load = 1'b1;
          end
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.scan_end) begin
          state_next = S_SDRAIN;
        end
      end
      S_SDRAIN: begin
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          if (stat.last_pick) begin
            state_next = S_IDLE;
          end else if (stat.found) begin
            state_next = S_DSET0;
          end else begin
            cmd.next_pick = 1'b1;
            state_next    = S_SCAN;
          end
        end
      end
      S_DSET0: begin
        cmd.disc_set0 = 1'b1;
        state_next    = S_DSET1;
      end
      S_DSET1: begin
        cmd.disc_set1 = 1'b1;
        state_next    = S_DROW;
      end
      S_DROW: begin
        cmd.disc_row = 1'b1;
        state_next   = S_DRUN;
      end
      S_DRUN: begin
        cmd.disc_step = 1'b1;
        if (stat.row_end) begin
          state_next = stat.disc_end ? S_DDRAIN : S_DROW;
        end
      end
      S_DDRAIN: begin
        // last mask write lands this cycle
        cmd.next_pick = 1'b1;
        state_next    = S_SCAN;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
// Testbench for the greedy peak picker: directed table, then random image phases vs. a predictor.
module tb;

  localparam int MAX_COLS    = 512;
  localparam int MAX_ROWS    = 512;
  localparam int MAX_PICKS   = 64;
  localparam int PIX_MAX     = MAX_COLS * MAX_ROWS;
  localparam int STALL_LIMIT = 20000;
  localparam int DIR_N       = 33;

  typedef enum logic [1:0] {ST_CFG, ST_LOAD, ST_START} step_kind_t;

  // one row of the directed script; n_typed = 0 means the predictor supplies the picks
  typedef struct packed {
    step_kind_t                     kind;
    logic [gppds_pkg::CFG_IDXW-1:0] reg_idx;
    logic [gppds_pkg::CFG_W-1:0]    value;
    logic [1:0]                     n_typed;
    gppds_pkg::out_t [0:2]          typed;
  } step_t;

  localparam gppds_pkg::out_t NO_PICK = '0;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  gppds_pkg::in_t  in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  gppds_pkg::out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [gppds_pkg::CFG_IDXW-1:0] cfg_index = '0;
  logic [gppds_pkg::CFG_W-1:0]    cfg_data = '0;

  // predictor state
  logic [gppds_pkg::PIX_W-1:0]   sal_mem [PIX_MAX];
  bit                            open_px [PIX_MAX];
  int unsigned                   load_addr = 0;
  int unsigned                   written_len = 0;
  logic [gppds_pkg::COLS_W-1:0]  cfg_cols = gppds_pkg::COLS_RST;
  logic [gppds_pkg::ROWS_W-1:0]  cfg_rows = gppds_pkg::ROWS_RST;
  logic [gppds_pkg::PICKS_W-1:0] cfg_picks = gppds_pkg::PICKS_RST;
  logic [gppds_pkg::RAD_W-1:0]   cfg_radius = gppds_pkg::RADIUS_RST;

  gppds_pkg::out_t new_picks [$];
  gppds_pkg::out_t expected_picks [$];
  gppds_pkg::out_t want;
  bit   run_started = 1'b0;
  int   mismatch_count = 0;
  int   pick_count = 0;
  int   quiet_cycles = 0;
  int   src_idle_pct = 0;
  int   snk_stall_pct = 0;

  step_t script [DIR_N] = '{
    '{ST_CFG,   gppds_pkg::REG_COLS,   10'd0,   2'd0, '0},
    '{ST_CFG,   gppds_pkg::REG_ROWS,   10'd0,   2'd0, '0},
    '{ST_CFG,   gppds_pkg::REG_PICKS,  10'd0,   2'd0, '0},
    '{ST_CFG,   gppds_pkg::REG_RADIUS, 10'd0,   2'd0, '0},
    '{ST_LOAD,  gppds_pkg::REG_COLS,   10'd255, 2'd0, '0},
    // single pixel image
    '{ST_START, gppds_pkg::REG_COLS,   10'd0,   2'd1,
      {{9'd0, 9'd0, 1'b1, 1'b1}, NO_PICK, NO_PICK}},
    '{ST_CFG,   gppds_pkg::REG_PICKS,  10'd2,   2'd0, '0},
    // restart on the same image: second pick finds nothing
    '{ST_START, gppds_pkg::REG_COLS,   10'd0,   2'd2,
      {{9'd0, 9'd0, 1'b1, 1'b0}, {9'd0, 9'd0, 1'b0, 1'b1}, NO_PICK}},
    '{ST_CFG,   gppds_pkg::REG_COLS,   10'd3,   2'd0, '0},
    '{ST_CFG,   gppds_pkg::REG_PICKS,  10'd3,   2'd0, '0},
    '{ST_LOAD,  gppds_pkg::REG_COLS,   10'd0,   2'd0, '0},
    '{ST_LOAD,  gppds_pkg::REG_COLS,   10'd7,   2'd0, '0},
    '{ST_LOAD,  gppds_pkg::REG_COLS,   10'd7,   2'd0, '0},
    // zero radius, tie goes to the first pixel
    '{ST_START, gppds_pkg::REG_COLS,   10'd0,   2'd3,
      {{9'd1, 9'd0, 1'b1, 1'b0}, {9'd2, 9'd0, 1'b1, 1'b0}, {9'd0, 9'd0, 1'b1, 1'b1}}},
    '{ST_CFG,   gppds_pkg::REG_PICKS,  10'd127, 2'd0, '0},
    '{ST_START, gppds_pkg::REG_COLS,   10'd0,   2'd0, '0},
    '{ST_CFG,   gppds_pkg::REG_COLS,   10'd2,   2'd0, '0},
    '{ST_CFG,   gppds_pkg::REG_ROWS,   10'd2,   2'd0, '0},
    '{ST_CFG,   gppds_pkg::REG_RADIUS, 10'd1,   2'd0, '0},
    '{ST_CFG,   gppds_pkg::REG_PICKS,  10'd2,   2'd0, '0},
    '{ST_LOAD,  gppds_pkg::REG_COLS,   10'd9,   2'd0, '0},
    '{ST_LOAD,  gppds_pkg::REG_COLS,   10'd0,   2'd0, '0},
    '{ST_LOAD,  gppds_pkg::REG_COLS,   10'd0,   2'd0, '0},
    '{ST_LOAD,  gppds_pkg::REG_COLS,   10'd200, 2'd0, '0},
    // radius 1 leaves the diagonal corner open
    '{ST_START, gppds_pkg::REG_COLS,   10'd0,   2'd2,
      {{9'd1, 9'd1, 1'b1, 1'b0}, {9'd0, 9'd0, 1'b1, 1'b1}, NO_PICK}},
    '{ST_CFG,   gppds_pkg::REG_RADIUS, 10'd511, 2'd0, '0},
    '{ST_START, gppds_pkg::REG_COLS,   10'd0,   2'd2,
      {{9'd1, 9'd1, 1'b1, 1'b0}, {9'd0, 9'd0, 1'b0, 1'b1}, NO_PICK}},
    // five loads into four pixels: the pointer wraps
    '{ST_LOAD,  gppds_pkg::REG_COLS,   10'd1,   2'd0, '0},
    '{ST_LOAD,  gppds_pkg::REG_COLS,   10'd2,   2'd0, '0},
    '{ST_LOAD,  gppds_pkg::REG_COLS,   10'd3,   2'd0, '0},
    '{ST_LOAD,  gppds_pkg::REG_COLS,   10'd4,   2'd0, '0},
    '{ST_LOAD,  gppds_pkg::REG_COLS,   10'd250, 2'd0, '0},
    '{ST_START, gppds_pkg::REG_COLS,   10'd0,   2'd0, '0}
  };

  greedy_peak_pick_disc_suppress_top DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic int eff_cols();
    if (cfg_cols == 0) return 1;
    if (cfg_cols > MAX_COLS) return MAX_COLS;
    return int'(cfg_cols);
  endfunction

  function automatic int eff_rows();
    if (cfg_rows == 0) return 1;
    if (cfg_rows > MAX_ROWS) return MAX_ROWS;
    return int'(cfg_rows);
  endfunction

  // settling margin waited after the last pick, sized from the image like a full disc sweep
  function automatic int settle_cycles();
    return 2 * eff_cols() * eff_rows() + eff_rows() + 16;
  endfunction

  function automatic void add_expected(input gppds_pkg::out_t p);
    expected_picks = {expected_picks, p};
  endfunction

  // updates the predictor for one accepted transaction; the picks it causes go to new_picks
  function automatic void compute_picks(input gppds_pkg::in_t item);
    int   cols, rows, total, picks, r, best, px, py, ylo, yhi, xlo, xhi;
    bit   have;
    logic [gppds_pkg::PIX_W-1:0] best_val;
    gppds_pkg::out_t pick;
    cols = eff_cols();
    rows = eff_rows();
    total = cols * rows;
    new_picks.delete();
    if (item.cmd == gppds_pkg::CMD_LOAD) begin
      if (load_addr >= total) load_addr = 0;
      sal_mem[load_addr] = item.pixel_value;
      if (load_addr + 1 > written_len) written_len = load_addr + 1;
      load_addr = (load_addr + 1) & 32'h3FFFF;
      return;
    end
    load_addr = 0;
    picks = (cfg_picks == 0) ? 1 : (cfg_picks > MAX_PICKS) ? MAX_PICKS : int'(cfg_picks);
    r = int'(cfg_radius);
    for (int a = 0; a < total; a++) open_px[a] = 1'b1;
    for (int k = 0; k < picks; k++) begin
      have = 1'b0;
      best = 0;
      best_val = '0;
      px = 0;
      py = 0;
      for (int a = 0; a < total; a++) begin
        if (open_px[a] && (!have || sal_mem[a] > best_val)) begin
          have = 1'b1;
          best = a;
          best_val = sal_mem[a];
        end
      end
      if (have) begin
        px = best % cols;
        py = best / cols;
        ylo = (py - r < 0) ? 0 : py - r;
        yhi = (py + r > rows - 1) ? rows - 1 : py + r;
        xlo = (px - r < 0) ? 0 : px - r;
        xhi = (px + r > cols - 1) ? cols - 1 : px + r;
        for (int y = ylo; y <= yhi; y++)
          for (int x = xlo; x <= xhi; x++)
            if ((x - px) * (x - px) + (y - py) * (y - py) <= r * r)
              open_px[y * cols + x] = 1'b0;
      end
      pick.peak_x = px[gppds_pkg::COORD_W-1:0];
      pick.peak_y = py[gppds_pkg::COORD_W-1:0];
      pick.found  = have;
      pick.last   = (k + 1 == picks);
      new_picks = {new_picks, pick};
    end
  endfunction

  task automatic report_mismatch(input string msg);
    $display("ERROR %0t: pick %0d: %s", $time, pick_count, msg);
    mismatch_count++;
  endtask

  // cfg_valid stays high after a write so back-to-back writes need no second
  // assignment in the same step; the next input transaction lowers it
  task automatic write_reg(input logic [gppds_pkg::CFG_IDXW-1:0] idx,
                           input logic [gppds_pkg::CFG_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    case (idx)
      gppds_pkg::REG_COLS:   cfg_cols = val;
      gppds_pkg::REG_ROWS:   cfg_rows = val;
      gppds_pkg::REG_PICKS:  cfg_picks = val[gppds_pkg::PICKS_W-1:0];
      gppds_pkg::REG_RADIUS: cfg_radius = val[gppds_pkg::RAD_W-1:0];
      default: ;
    endcase
  endtask

  task automatic send_item(input gppds_pkg::in_t item, input bit from_model);
    cfg_valid <= 1'b0;
    if ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall !== 1'b0);
    compute_picks(item);
    if (item.cmd == gppds_pkg::CMD_START) run_started = 1'b1;
    if (from_model)
      foreach (new_picks[k]) add_expected(new_picks[k]);
  endtask

  // all picks in, then wait out a settling margin
  task automatic wait_idle();
    in_valid <= 1'b0;
    if (run_started) begin
      while (expected_picks.size() != 0) @(posedge clk);
      repeat (settle_cycles()) @(posedge clk);
      run_started = 1'b0;
    end
  endtask

  // result side: stall and check
  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && out_stall == 1'b0) begin
      if (expected_picks.size() == 0) begin
        report_mismatch("result transaction with nothing expected");
      end else begin
        want = expected_picks.pop_front();
        if (out_data.peak_x !== want.peak_x)
          report_mismatch($sformatf("peak_x %0d, expected %0d", out_data.peak_x, want.peak_x));
        if (out_data.peak_y !== want.peak_y)
          report_mismatch($sformatf("peak_y %0d, expected %0d", out_data.peak_y, want.peak_y));
        if (out_data.found !== want.found)
          report_mismatch($sformatf("found %0b, expected %0b", out_data.found, want.found));
        if (out_data.last !== want.last)
          report_mismatch($sformatf("last %0b, expected %0b", out_data.last, want.last));
      end
      pick_count++;
    end
    out_stall <= ($urandom_range(99) < snk_stall_pct);
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("greedy_peak_pick_disc_suppress_top test failed");
      $finish;
    end
  end

  initial begin
    int   phase, n_img, n_load, total, style;
    bit   narrow;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < DIR_N; i++) begin
      if (script[i].kind == ST_CFG) begin
        if (i == 0 || script[i-1].kind != ST_CFG) wait_idle();
        write_reg(script[i].reg_idx, script[i].value);
      end else begin
        send_item(gppds_pkg::in_t'{(script[i].kind == ST_START) ? gppds_pkg::CMD_START
                                                                 : gppds_pkg::CMD_LOAD,
                                   script[i].value[gppds_pkg::PIX_W-1:0]},
                  script[i].n_typed == 0);
        for (int j = 0; j < script[i].n_typed; j++)
          add_expected(script[i].typed[j]);
      end
    end

    for (phase = 0; phase < 8; phase++) begin
      case (phase % 4)
        0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
        1: begin src_idle_pct = 72; snk_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  snk_stall_pct = 72; end
        default: begin src_idle_pct = 9; snk_stall_pct = 9; end
      endcase
      wait_idle();
      if (phase == 0 || $urandom_range(3) != 0)
        write_reg(gppds_pkg::REG_COLS,
                  ($urandom_range(9) == 0) ? 10'd0 : 10'($urandom_range(1, 12)));
      if (phase == 0 || $urandom_range(3) != 0)
        write_reg(gppds_pkg::REG_ROWS,
                  ($urandom_range(9) == 0) ? 10'd0 : 10'($urandom_range(1, 6)));
      if (phase == 0 || $urandom_range(3) != 0) begin
        case ($urandom_range(9))
          0: write_reg(gppds_pkg::REG_PICKS, 10'd0);
          1: write_reg(gppds_pkg::REG_PICKS, 10'd127);
          2: write_reg(gppds_pkg::REG_PICKS, 10'd64);
          default: write_reg(gppds_pkg::REG_PICKS, 10'($urandom_range(1, 8)));
        endcase
      end
      if (phase == 0 || $urandom_range(3) != 0) begin
        case ($urandom_range(9))
          0: write_reg(gppds_pkg::REG_RADIUS, 10'd511);
          1: write_reg(gppds_pkg::REG_RADIUS, 10'($urandom_range(0, 511)));
          default: write_reg(gppds_pkg::REG_RADIUS, 10'($urandom_range(0, 4)));
        endcase
      end
      n_img = $urandom_range(2, 4);
      for (int m = 0; m < n_img; m++) begin
        total = eff_cols() * eff_rows();
        style = $urandom_range(99);
        if (style < 78 || written_len < total) n_load = total;
        else if (style < 88) n_load = total + $urandom_range(1, total + 2);
        else if (style < 95) n_load = $urandom_range(0, total - 1);
        else n_load = 0;
        // a narrow value range makes ties common
        narrow = ($urandom_range(3) == 0);
        repeat (n_load)
          send_item(gppds_pkg::in_t'{gppds_pkg::CMD_LOAD,
                                     narrow ? 8'($urandom_range(2)) : 8'($urandom_range(255))},
                    1'b1);
        send_item(gppds_pkg::in_t'{gppds_pkg::CMD_START, 8'($urandom_range(255))}, 1'b1);
      end
    end

    wait_idle();
    if (mismatch_count == 0)
      $display("greedy_peak_pick_disc_suppress_top test passed");
    else
      $display("greedy_peak_pick_disc_suppress_top test failed");
    $finish;
  end

endmodule

// ----- filelist.f -----
design/gppds_pkg.sv
design/gppds_dp.sv
design/gppds_ctrl.sv
design/greedy_peak_pick_disc_suppress_top.sv
tb/tb.sv
